// ===== design/kwsc_pkg.sv =====
// Shared codes, constants, types and the letter decoder of the keyword cipher.
package kwsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE + 1);

    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_KEYWORD = 3'd1;
    localparam logic [2:0] FUNC_SEAL    = 3'd2;
    localparam logic [2:0] FUNC_ENCRYPT = 3'd3;
    localparam logic [2:0] FUNC_DECRYPT = 3'd4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(ALPHABET_SIZE - 1);
    localparam logic [IDX_W-1:0] FULL_COUNT  = IDX_W'(ALPHABET_SIZE);

    // Update request to the table unit
    typedef struct packed {
        logic             clear;
        logic             place;
        logic [IDX_W-1:0] idx;
    } place_req_t;

    // Lookup request to the table unit
    typedef struct packed {
        logic             read;
        logic             inverse;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    // Decoded text byte
    typedef struct packed {
        logic             is_letter;
        logic             lower;
        logic [IDX_W-1:0] idx;
    } letter_t;

    function automatic letter_t letter_decode(input logic [7:0] b);
        letter_t    d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            diff        = b - CHAR_UPPER_A;
            d.is_letter = 1'b1;
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            diff        = b - CHAR_LOWER_A;
            d.is_letter = 1'b1;
            d.lower     = 1'b1;
        end
        d.idx = diff[IDX_W-1:0];
        return d;
    endfunction

endpackage

// ===== design/kwsc_ifs.sv =====
// Request and result channel interfaces of the keyword cipher.
interface kwsc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface kwsc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== design/keyword_substitution_cipher.sv =====
// Top level of the keyword substitution cipher.
// Requests carry a function code and a byte. Clear (0) empties the alphabet, keyword
// letter (1) appends the upper-cased letter if not yet used (non-letters are ignored),
// seal (2) appends the remaining letters A to Z in order, encrypt (3) and decrypt (4)
// return one result byte mapped through the forward or inverse table with case kept and
// non-letters passed unchanged; codes 5 to 7 are dropped. During seal the place unit
// walks one letter per cycle. For encrypt and decrypt the table is read as the request
// is accepted, and the result register is loaded from that registered read in the map
// state once the register is free or being taken. A result waiting in that register
// holds back only the next encrypt or decrypt, which waits in the map state until the
// result is taken. Text must not be mapped before a keyword and seal have filled the
// table.
module keyword_substitution_cipher
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kwsc_req_if.sink   text,
    kwsc_rsp_if.source result
);

    place_req_t       place_req;
    lookup_t          lookup;
    logic [IDX_W-1:0] map_idx;

    kwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .result    (result),
        .place_req (place_req),
        .lookup    (lookup),
        .map_idx   (map_idx)
    );

    kwsc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .place_req (place_req),
        .lookup    (lookup),
        .map_idx   (map_idx)
    );

endmodule

// ===== design/kwsc_table.sv =====
// Substitution tables, used-letter map and fill position with the shared place unit.
module kwsc_table
    import kwsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  place_req_t       place_req,
    input  lookup_t          lookup,
    output logic [IDX_W-1:0] map_idx
);

    logic [IDX_W-1:0]         fwd_mem [ALPHABET_SIZE];
    logic [IDX_W-1:0]         inv_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] used_reg;
    logic [ALPHABET_SIZE-1:0] used_next;
    logic [IDX_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         fill_next;
    logic [IDX_W-1:0]         map_reg;
    logic                     do_place;

    // Place a letter only when it is new and the table has room
    assign do_place = place_req.place && !place_req.clear
                      && !used_reg[place_req.idx] && (fill_reg < FULL_COUNT);

    always_comb
    begin
        used_next = used_reg;
        fill_next = fill_reg;
        if (place_req.clear)
        begin
            used_next = '0;
            fill_next = '0;
        end
        else if (do_place)
        begin
            used_next[place_req.idx] = 1'b1;
            fill_next                = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            fill_reg <= fill_next;
        end
    end

    // Write both tables together; register the read of the selected table
    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            fwd_mem[fill_reg]      <= place_req.idx;
            inv_mem[place_req.idx] <= fill_reg;
        end
        if (lookup.read)
            map_reg <= lookup.inverse ? inv_mem[lookup.idx] : fwd_mem[lookup.idx];
    end

    assign map_idx = map_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill position beyond alphabet");

    a_fill_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(fill_reg))
        else $error("used-letter count differs from fill position");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        place_req.clear |=> (fill_reg == '0 && used_reg == '0))
        else $error("clear did not empty the alphabet");
`endif

endmodule

// ===== design/kwsc_ctrl.sv =====
// Sequencer: request decode, seal walk over the letters, lookup and result register.
module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    kwsc_req_if.sink         text,
    kwsc_rsp_if.source       result,
    output place_req_t       place_req,
    output lookup_t          lookup,
    input  logic [IDX_W-1:0] map_idx
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEAL = 3'b010,
        S_MAP  = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] seal_cnt_reg;
    logic [IDX_W-1:0] seal_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             lower_reg;
    logic             letter_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       out_byte_reg;
    logic             accept;
    logic             load_out;
    letter_t          dec;
    logic [IDX_W-1:0] cipher_idx;
    logic [7:0]       mapped_byte;

    assign text.ready      = (state_reg == S_IDLE);
    assign accept          = text.valid && text.ready;
    assign dec             = letter_decode(text.in_byte);
    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;

    // Load the result register once it is free or being taken
    assign load_out = (state_reg == S_MAP) && (!out_valid_reg || result.ready);

    // Drive clear and place requests
    always_comb
    begin
        place_req = '0;
        if (state_reg == S_SEAL)
        begin
            place_req.place = 1'b1;
            place_req.idx   = seal_cnt_reg;
        end
        else if (accept)
        begin
            place_req.clear = (text.func == FUNC_CLEAR);
            place_req.place = (text.func == FUNC_KEYWORD) && dec.is_letter;
            place_req.idx   = dec.idx;
        end
    end

    // Start the table read as the text byte is accepted
    always_comb
    begin
        lookup.read    = accept
                         && (text.func == FUNC_ENCRYPT || text.func == FUNC_DECRYPT);
        lookup.inverse = (text.func == FUNC_DECRYPT);
        lookup.idx     = dec.idx;
    end

    // Advance the sequencer
    always_comb
    begin
        state_next    = state_reg;
        seal_cnt_next = seal_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                seal_cnt_next = '0;
                if (accept)
                begin
                    if (text.func == FUNC_SEAL)
                        state_next = S_SEAL;
                    else if (text.func == FUNC_ENCRYPT || text.func == FUNC_DECRYPT)
                        state_next = S_MAP;
                end
            end
            S_SEAL:
            begin
                seal_cnt_next = seal_cnt_reg + 1'b1;
                if (seal_cnt_reg == LAST_LETTER)
                    state_next = S_IDLE;
            end
            S_MAP:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set the result flag on load, drop it when the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seal_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seal_cnt_reg  <= seal_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request byte and its decode for the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lower_reg  <= dec.lower;
            letter_reg <= dec.is_letter;
            byte_reg   <= text.in_byte;
        end
    end

    // Form the mapped character, keeping case; out-of-range indexes read as A
    assign cipher_idx  = (map_idx >= FULL_COUNT) ? '0 : map_idx;
    assign mapped_byte = (lower_reg ? CHAR_LOWER_A : CHAR_UPPER_A)
                         + {{(8-IDX_W){1'b0}}, cipher_idx};

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_byte_reg <= letter_reg ? mapped_byte : byte_reg;
    end

endmodule

// ===== bench/tb_keyword_substitution_cipher.sv =====
// Self-checking testbench of the keyword substitution cipher with its own cipher predictor.
module tb_keyword_substitution_cipher;
    import kwsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Function codes that the block drops
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [2:0] func;
        logic [7:0] in_byte;
        logic [7:0] out_byte;
    } cipher_result_t;

    logic clk;
    logic rst_n;

    kwsc_req_if text_if();
    kwsc_rsp_if result_if();

    keyword_substitution_cipher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    // Predicted cipher state
    logic [IDX_W-1:0] fwd_map [ALPHABET_SIZE];
    logic [IDX_W-1:0] inv_map [ALPHABET_SIZE];
    logic [25:0]      letters_used;
    logic [IDX_W-1:0] fill_pos;
    bit   [25:0]      fwd_known;
    bit   [25:0]      inv_known;

    cipher_result_t   cipher_bytes_due [$];

    bit bursts_on;
    int hold_off_cycles;
    int mismatch_count;
    int bytes_checked;
    int work_items;
    int encrypt_count;
    int decrypt_count;
    int seal_count;
    int long_stalls;
    int drain_pauses;

    always #1 clk = ~clk;

    // Return 1 and the letter index when the byte is a letter
    function automatic bit letter_of(input logic [7:0] b, output int idx, output bit lower);
        idx   = 0;
        lower = 1'b0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            idx = int'(b - CHAR_UPPER_A);
            return 1'b1;
        end
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            idx   = int'(b - CHAR_LOWER_A);
            lower = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void place_letter(input int idx);
        if (letters_used[idx] || fill_pos >= ALPHABET_SIZE)
            return;
        fwd_map[fill_pos]   = IDX_W'(idx);
        fwd_known[fill_pos] = 1'b1;
        inv_map[idx]        = fill_pos;
        inv_known[idx]      = 1'b1;
        fill_pos            = fill_pos + 1'b1;
        letters_used[idx]   = 1'b1;
    endfunction

    // Advance the predicted state by one accepted request and queue any output byte
    function automatic void apply_cipher_request(input logic [2:0] f, input logic [7:0] b);
        int             idx;
        bit             lower;
        logic [IDX_W-1:0] v;
        cipher_result_t r;
        case (f)
            FUNC_CLEAR:
            begin
                letters_used = '0;
                fill_pos     = '0;
            end
            FUNC_KEYWORD:
                if (letter_of(b, idx, lower))
                    place_letter(idx);
            FUNC_SEAL:
            begin
                seal_count++;
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    place_letter(i);
            end
            FUNC_ENCRYPT, FUNC_DECRYPT:
            begin
                r.func    = f;
                r.in_byte = b;
                r.out_byte = b;
                if (f == FUNC_ENCRYPT)
                    encrypt_count++;
                else
                    decrypt_count++;
                if (letter_of(b, idx, lower))
                begin
                    v = (f == FUNC_ENCRYPT) ? fwd_map[idx] : inv_map[idx];
                    if (v >= ALPHABET_SIZE)
                        v = '0;
                    r.out_byte = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v);
                end
                cipher_bytes_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_non_letter();
        logic [7:0] b;
        int         idx;
        bit         lower;
        do
            b = 8'($urandom_range(0, 255));
        while (letter_of(b, idx, lower));
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A)
               + 8'($urandom_range(0, ALPHABET_SIZE - 1));
    endfunction

    // Text byte whose table entry has been written, or a non-letter
    function automatic logic [7:0] pick_text_byte(input bit inverse);
        bit [25:0] ok;
        int        idx;
        ok = inverse ? inv_known : fwd_known;
        if (ok == '0 || $urandom_range(0, 3) == 0)
            return pick_non_letter();
        do
            idx = $urandom_range(0, ALPHABET_SIZE - 1);
        while (!ok[idx]);
        return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(idx);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [2:0] f, input logic [7:0] b);
        int idx;
        bit lower;
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        text_if.valid   <= 1'b1;
        text_if.func    <= f;
        text_if.in_byte <= b;
        do
            @(posedge clk);
        while (text_if.ready !== 1'b1);
        apply_cipher_request(f, b);
        if (f <= FUNC_DECRYPT && !(f == FUNC_KEYWORD && !letter_of(b, idx, lower)))
            work_items++;
    endtask

    // Drop valid and wait until every queued byte has come back
    task automatic pause_until_drained();
        text_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (cipher_bytes_due.size() != 0);
    endtask

    task automatic send_text(input int count);
        logic [2:0] f;
        for (int i = 0; i < count; i++)
        begin
            f = $urandom_range(0, 1) ? FUNC_ENCRYPT : FUNC_DECRYPT;
            send_request(f, pick_text_byte(f == FUNC_DECRYPT));
        end
    endtask

    task automatic test_directed_cases();
        bursts_on = 1'b0;
        // Non-letters before any keyword, range edges around both letter ranges
        send_request(FUNC_ENCRYPT, 8'h00);
        send_request(FUNC_DECRYPT, 8'hFF);
        send_request(FUNC_ENCRYPT, CHAR_UPPER_A - 8'd1);
        send_request(FUNC_DECRYPT, CHAR_UPPER_Z + 8'd1);
        send_request(FUNC_ENCRYPT, CHAR_LOWER_A - 8'd1);
        send_request(FUNC_DECRYPT, CHAR_LOWER_Z + 8'd1);
        // Unknown codes are dropped
        send_request(FUNC_UNUSED_FIRST, CHAR_UPPER_A);
        send_request(FUNC_UNUSED_LAST, CHAR_LOWER_Z);
        // Keyword with mixed case, a repeat and non-letter bytes
        send_request(FUNC_KEYWORD, CHAR_LOWER_Z);
        send_request(FUNC_KEYWORD, CHAR_UPPER_A + 8'd4);
        send_request(FUNC_KEYWORD, CHAR_LOWER_A + 8'd1);
        send_request(FUNC_KEYWORD, CHAR_UPPER_Z);
        send_request(FUNC_KEYWORD, 8'h37);
        send_request(FUNC_KEYWORD, CHAR_UPPER_A | 8'h80);
        send_request(FUNC_KEYWORD, CHAR_LOWER_A);
        // Seal twice, then a keyword letter into the full table
        send_request(FUNC_SEAL, 8'h00);
        send_request(FUNC_SEAL, 8'hFF);
        send_request(FUNC_KEYWORD, CHAR_UPPER_A + 8'd16);
        send_request(FUNC_ENCRYPT, CHAR_UPPER_A);
        send_request(FUNC_ENCRYPT, CHAR_UPPER_Z);
        send_request(FUNC_ENCRYPT, CHAR_LOWER_Z);
        send_request(FUNC_DECRYPT, CHAR_LOWER_A);
        // Clear keeps the tables; a new keyword overwrites from the first slot
        send_request(FUNC_CLEAR, 8'hA5);
        send_request(FUNC_KEYWORD, CHAR_LOWER_A + 8'd12);
        send_request(FUNC_ENCRYPT, CHAR_UPPER_A);
        send_request(FUNC_DECRYPT, CHAR_LOWER_A + 8'd12);
        send_request(FUNC_DECRYPT, CHAR_UPPER_Z);
        send_request(FUNC_SEAL, 8'h5A);
    endtask

    // Keyword sessions with random content, some noise and some broken sequences
    task automatic test_random_sessions(input int goal, input bit allow_bursts);
        int klen;
        int r;
        while (work_items < goal)
        begin
            bursts_on = allow_bursts && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0)
                send_request(FUNC_CLEAR, 8'($urandom_range(0, 255)));
            klen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            for (int k = 0; k < klen; k++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_request(FUNC_KEYWORD, pick_non_letter());
                else if (r == 1)
                    send_request(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                                 8'($urandom_range(0, 255)));
                else
                    send_request(FUNC_KEYWORD, pick_letter());
            end
            if ($urandom_range(0, 7) != 0)
                send_request(FUNC_SEAL, 8'($urandom_range(0, 255)));
            send_text($urandom_range(4, 40));
        end
    endtask

    // Stall the result side for a long stretch while text keeps coming
    task automatic test_result_stall();
        bursts_on       = 1'b1;
        hold_off_cycles = 150;
        send_text(16);
        pause_until_drained();
        drain_pauses++;
        send_text(8);
    endtask

    task automatic test_full_rate();
        bursts_on = 1'b0;
        test_random_sessions(work_items + 200, 1'b0);
    endtask

    // Result side: random stalls and the requested long hold-off
    initial
    begin : result_taker
        int n;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
                long_stalls++;
                result_if.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge clk);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest predicted byte
    initial
    begin : result_check
        cipher_result_t r;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                bytes_checked++;
                if (cipher_bytes_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, got 0x%02h",
                             $realtime, result_if.out_byte);
                end
                else
                begin
                    r = cipher_bytes_due.pop_front();
                    if (result_if.out_byte !== r.out_byte)
                    begin
                        mismatch_count++;
                        $display("%0t: out_byte for func %0d in_byte 0x%02h: expected 0x%02h, got 0x%02h",
                                 $realtime, r.func, r.in_byte, r.out_byte, result_if.out_byte);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb_keyword_substitution_cipher: FAIL");
        $finish;
    end

    initial
    begin : run_tests
        clk             = 1'b0;
        rst_n           = 1'b0;
        text_if.valid   = 1'b0;
        text_if.func    = FUNC_CLEAR;
        text_if.in_byte = 8'h00;
        bursts_on       = 1'b0;
        hold_off_cycles = 0;
        letters_used    = '0;
        fill_pos        = '0;
        fwd_known       = '0;
        inv_known       = '0;
        foreach (fwd_map[i])
        begin
            fwd_map[i] = '0;
            inv_map[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_result_stall();
        test_random_sessions(1750, 1'b1);
        test_full_rate();

        // Let the last results come back
        pause_until_drained();
        repeat (40) @(posedge clk);

        $display("Sent %0d working requests: %0d encrypt, %0d decrypt, %0d seal; %0d bytes checked.",
                 work_items, encrypt_count, decrypt_count, seal_count, bytes_checked);
        $display("Covered %0d long result stall(s), %0d drain pause(s), bursts and full-rate text.",
                 long_stalls, drain_pauses);
        if (mismatch_count == 0 && cipher_bytes_due.size() == 0)
            $display("tb_keyword_substitution_cipher: PASS");
        else
            $display("tb_keyword_substitution_cipher: FAIL");
        $finish;
    end

endmodule

// ===== keyword_substitution_cipher.f =====
design/kwsc_pkg.sv
design/kwsc_ifs.sv
design/kwsc_table.sv
design/kwsc_ctrl.sv
design/keyword_substitution_cipher.sv
bench/tb_keyword_substitution_cipher.sv
